// ===== rtl/singly_linked_list_manager_assert.svh =====
// ----------------------------------------------------------------------------
// singly_linked_list_manager_assert
// Assertion macros for the linked list manager.
// ----------------------------------------------------------------------------
`ifndef SINGLY_LINKED_LIST_MANAGER_ASSERT_SVH
`define SINGLY_LINKED_LIST_MANAGER_ASSERT_SVH
// Property that must hold on every edge outside reset.
`define SLL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property that must hold on every edge, reset included.
`define SLL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/sll_pkg.sv =====
// ----------------------------------------------------------------------------
// sll_pkg
// Shared types and constants for the linked list manager.
// ----------------------------------------------------------------------------
package sll_pkg;
  localparam int Capacity = 32;
  localparam int SlotW = $clog2(Capacity);
  localparam int CountW = $clog2(Capacity + 1);

  typedef logic [SlotW-1:0] slot_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [2:0] {
    FN_INS_HEAD  = 3'd0,
    FN_INS_AFTER = 3'd1,
    FN_APPEND    = 3'd2,
    FN_DEL_HEAD  = 3'd3,
    FN_DEL_KEY   = 3'd4,
    FN_DEL_TAIL  = 3'd5,
    FN_RSVD6     = 3'd6,
    FN_RSVD7     = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_WAIT,
    S_WALK_CHK,
    S_FREE_RD,
    S_FREE_WAIT,
    S_COMMIT,
    S_DEL_RD,
    S_DEL_WAIT,
    S_DEL_COMMIT,
    S_OUT
  } state_t;
endpackage

// ===== rtl/sll_ram.sv =====
// ----------------------------------------------------------------------------
// sll_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sll_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/singly_linked_list_manager.sv =====
// ----------------------------------------------------------------------------
// singly_linked_list_manager
// Linked list of signed values held in a value RAM and a next-pointer RAM.
//
// Channel  Dir  Ports
// in       in   valid, ready, func, value, key
// out      out  out_valid, out_ready, removed_value, status, count
//
// A full store, an empty list for a delete or an unused code goes straight to the
// result. Head insert and a first node read the free list and commit; head delete reads
// the head node; append also links the old tail. Searches and tail delete read one node
// at a time, then link after a hit, unlink, or free the tail; a miss ends the walk. One item at a time.
// Reset is synchronous and clears head, tail, free-list pointer and node counters; RAMs are not cleared.
// A result waiting at the output holds the next one in S_OUT.
// ----------------------------------------------------------------------------
module singly_linked_list_manager
  import sll_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               ready,
  input  logic [2:0]         func,
  input  logic signed [31:0] value,
  input  logic signed [31:0] key,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] removed_value,
  output logic [1:0]         status,
  output logic [5:0]         count
);
  `include "singly_linked_list_manager_assert.svh"

  state_t state, state_next;
  slot_t head, tail, free_head, cur, prev, alloc;
  count_t freed, fresh, list_cnt, idx;
  logic [2:0] op;
  logic [31:0] val_r, key_r;
  logic [31:0] res_removed;
  status_t     res_status;

  logic        v_we, n_we;
  slot_t       v_addr, n_addr;
  logic [31:0] v_wd, v_rd;
  slot_t       n_wd, n_rd;

  // second write for insert-after / append / delete-key / tail-delete commit
  logic  commit2;
  slot_t found_next;

  logic full, hit, skip_head;

  sll_ram #(.Width(32), .Depth(Capacity)) u_val (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wd), .rdata(v_rd));
  sll_ram #(.Width(SlotW), .Depth(Capacity)) u_next (
    .clk(clk), .we(n_we), .addr(n_addr), .wdata(n_wd), .rdata(n_rd));

  assign full = (list_cnt == count_t'(Capacity));
  assign hit = (v_rd == key_r);
  assign skip_head = (idx == count_t'(1)) && (cur == prev) && (list_cnt != count_t'(1));
  assign ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (valid && ready) begin
        case (func)
          FN_INS_HEAD, FN_APPEND:
            state_next = full ? S_OUT : S_FREE_RD;
          FN_INS_AFTER:
            state_next = full ? S_OUT : ((list_cnt == '0) ? S_FREE_RD : S_WALK_RD);
          FN_DEL_HEAD, FN_DEL_KEY, FN_DEL_TAIL:
            state_next = (list_cnt == '0) ? S_OUT : S_WALK_RD;
          default: state_next = S_OUT;
        endcase
      end
      S_WALK_RD: state_next = S_WALK_WAIT;
      S_WALK_WAIT: state_next = S_WALK_CHK;
      S_WALK_CHK: begin
        case (op)
          FN_INS_AFTER: begin
            if (hit) state_next = S_FREE_RD;
            else if (idx + count_t'(1) == list_cnt) state_next = S_OUT;
            else state_next = S_WALK_RD;
          end
          FN_DEL_HEAD: state_next = S_DEL_COMMIT;
          FN_DEL_KEY: begin
            if (skip_head) state_next = S_WALK_RD;
            else if (list_cnt == count_t'(1)) state_next = S_OUT;
            else if (hit) state_next = S_DEL_COMMIT;
            else if (idx == list_cnt) state_next = S_OUT;
            else state_next = S_WALK_RD;
          end
          default: state_next = (idx == list_cnt) ? S_DEL_COMMIT : S_WALK_RD;
        endcase
      end
      S_FREE_RD: state_next = S_FREE_WAIT;
      S_FREE_WAIT: state_next = S_COMMIT;
      S_COMMIT: state_next = (op == FN_INS_HEAD || list_cnt == '0) ? S_OUT : S_DEL_RD;
      S_DEL_RD: state_next = S_DEL_WAIT;
      S_DEL_WAIT: state_next = S_DEL_COMMIT;
      S_DEL_COMMIT:
        state_next = (op == FN_INS_AFTER || op == FN_APPEND || !commit2) ?
                     S_OUT : S_DEL_COMMIT;
      S_OUT: state_next = (!out_valid || out_ready) ? S_IDLE : S_OUT;
      default: state_next = S_IDLE;
    endcase
  end

  // RAM port control
  always_comb begin
    v_we = 1'b0; n_we = 1'b0;
    v_addr = cur; n_addr = cur;
    v_wd = val_r; n_wd = '0;
    case (state)
      S_FREE_RD: n_addr = free_head;
      S_COMMIT: begin
        v_we = 1'b1; n_we = 1'b1; v_addr = alloc; n_addr = alloc;
        case (op)
          FN_INS_HEAD:  n_wd = (list_cnt == '0) ? slot_t'(0) : head;
          FN_INS_AFTER: n_wd = (list_cnt == '0) ? slot_t'(0) : found_next;
          default:      n_wd = '0;
        endcase
      end
      S_DEL_COMMIT: begin
        n_we = 1'b1;
        n_addr = commit2 ? prev : cur;
        n_wd = commit2 ? alloc : free_head;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; head <= '0; tail <= '0; free_head <= '0;
      freed <= '0; fresh <= '0; list_cnt <= '0; out_valid <= 1'b0;
      commit2 <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1; removed_value <= res_removed; status <= res_status;
        count <= 6'(list_cnt);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (valid && ready) begin
          op <= func; val_r <= value; key_r <= key;
          res_removed <= '0; commit2 <= 1'b0;
          cur <= head; prev <= head;
          case (func)
            FN_INS_HEAD, FN_INS_AFTER, FN_APPEND: begin
              idx <= '0;
              res_status <= full ? ST_FULL : ST_OK;
            end
            FN_DEL_HEAD, FN_DEL_KEY, FN_DEL_TAIL: begin
              idx <= count_t'(1);
              res_status <= (list_cnt == '0) ? ST_EMPTY : ST_OK;
            end
            default: begin
              idx <= '0;
              res_status <= ST_OK;
            end
          endcase
        end
        S_WALK_CHK: begin
          // v_rd/n_rd hold node cur
          case (op)
            FN_INS_AFTER: begin
              if (hit) begin
                found_next <= n_rd; prev <= cur;
              end else if (idx + count_t'(1) == list_cnt) begin
                res_status <= ST_NOTFOUND;
              end else begin
                idx <= idx + count_t'(1); cur <= n_rd;
              end
            end
            FN_DEL_HEAD: begin
              res_removed <= v_rd;
              head <= n_rd;
            end
            FN_DEL_KEY: begin
              if (skip_head) begin
                cur <= n_rd; idx <= count_t'(2);
              end else if (list_cnt == count_t'(1)) begin
                res_status <= ST_NOTFOUND;
              end else if (hit) begin
                res_removed <= v_rd; alloc <= n_rd; commit2 <= 1'b1;
                if (cur == tail) tail <= prev;
              end else if (idx == list_cnt) begin
                res_status <= ST_NOTFOUND;
              end else begin
                prev <= cur; cur <= n_rd; idx <= idx + count_t'(1);
              end
            end
            default: begin
              if (idx == list_cnt) begin
                res_removed <= v_rd;
                if (list_cnt != count_t'(1)) begin
                  alloc <= '0; commit2 <= 1'b1; tail <= prev;
                end
              end else begin
                prev <= cur; cur <= n_rd; idx <= idx + count_t'(1);
              end
            end
          endcase
        end
        S_FREE_WAIT: begin
          if (freed != '0) begin
            alloc <= free_head; free_head <= n_rd; freed <= freed - count_t'(1);
          end else begin
            alloc <= fresh[SlotW-1:0]; fresh <= fresh + count_t'(1);
          end
        end
        S_COMMIT: begin
          list_cnt <= list_cnt + count_t'(1);
          case (op)
            FN_INS_HEAD: begin
              head <= alloc;
              if (list_cnt == '0) tail <= alloc;
            end
            FN_APPEND: begin
              tail <= alloc;
              if (list_cnt == '0) begin
                head <= alloc;
              end else begin
                prev <= tail; commit2 <= 1'b1;
              end
            end
            default: begin
              if (list_cnt == '0) begin
                head <= alloc; tail <= alloc;
              end else begin
                if (prev == tail) tail <= alloc;
                commit2 <= 1'b1;
              end
            end
          endcase
        end
        S_DEL_COMMIT: begin
          if (op == FN_INS_AFTER || op == FN_APPEND) begin
            commit2 <= 1'b0;
          end else if (commit2) begin
            commit2 <= 1'b0;
          end else begin
            free_head <= cur; freed <= freed + count_t'(1);
            list_cnt <= list_cnt - count_t'(1);
            if (list_cnt == count_t'(1)) begin
              head <= '0; tail <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  `SLL_ASSERT(a_cnt_range, list_cnt <= count_t'(Capacity), "count above capacity")
  `SLL_ASSERT(a_no_accept_busy, (state != S_IDLE) |-> !ready, "ready while busy")
  `SLL_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid && $stable(status), "beat lost")
  `SLL_ASSERT(a_empty, (state == S_IDLE && list_cnt == '0) |-> (head | tail) == '0, "stale ptr")
  `SLL_ASSERT_RST(a_rst_idle, rst |=> (!out_valid && state == S_IDLE), "not idle after reset")
endmodule
